### sv/h264fua_pkg.sv
// Shared types and constants of the H.264 FU-A fragmenter.
package h264fua_pkg;

  // Default width of the NAL length field
  localparam int unsigned LENGTH_BITS_DEF = 24;

  // Reset values of the configuration registers
  localparam logic [6:0]  PT_RESET    = 7'd96;
  localparam logic [12:0] LIMIT_RESET = 13'd1400;

  // Legal range of the fragment limit
  localparam logic [12:0] LIMIT_MIN = 13'd16;
  localparam logic [12:0] LIMIT_MAX = 13'd4096;

  // NAL unit type of an FU-A packet
  localparam logic [4:0] FU_A_TYPE = 5'd28;

  // FU header flags
  localparam logic [2:0] FU_START = 3'b100;
  localparam logic [2:0] FU_END   = 3'b010;
  localparam logic [2:0] FU_MID   = 3'b000;

  // Results caused by one input byte, at most
  localparam int unsigned MAX_RES = 3;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_PAYLOAD_TYPE   = 1'b0,
    CFG_FRAGMENT_LIMIT = 1'b1
  } cfg_idx_e;

  // One emitted payload byte with its packet context
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        packet_start;
    logic        packet_end;
    logic        marker;
    logic [15:0] sequence_res;
    logic [31:0] timestamp_out;
    logic [12:0] packet_length;
    logic [6:0]  type_out;
    logic        last_of_run;
  } result_t;

  // All results of one input byte, in order, with their count
  typedef struct packed {
    result_t [MAX_RES-1:0] res;
    logic [1:0]            cnt;
  } run_t;

endpackage

### sv/h264fua_if.sv
// Request channel interfaces of the H.264 FU-A fragmenter.
interface h264fua_in_if #(
  parameter int unsigned LENGTH_BITS = h264fua_pkg::LENGTH_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [7:0]             data_byte;
  logic [LENGTH_BITS-1:0] nal_length;
  logic [31:0]            timestamp;

  modport source (output valid, output data_byte, output nal_length, output timestamp,
                  input ready);
  modport sink   (input valid, input data_byte, input nal_length, input timestamp,
                  output ready);
endinterface

interface h264fua_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        packet_start;
  logic        packet_end;
  logic        marker;
  logic [15:0] sequence_res;
  logic [31:0] timestamp_out;
  logic [12:0] packet_length;
  logic [6:0]  type_out;
  logic        last_of_run;

  modport source (output valid, output out_byte, output packet_start, output packet_end,
                  output marker, output sequence_res, output timestamp_out,
                  output packet_length, output type_out, output last_of_run,
                  input ready);
  modport sink   (input valid, input out_byte, input packet_start, input packet_end,
                  input marker, input sequence_res, input timestamp_out,
                  input packet_length, input type_out, input last_of_run,
                  output ready);
endinterface

interface h264fua_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [12:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/h264fua_core.sv
// Unit tracking state and per-byte packetizing logic.
module h264fua_core #(
  parameter int unsigned LENGTH_BITS = h264fua_pkg::LENGTH_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic [7:0]             data_byte_i,
  input  logic [LENGTH_BITS-1:0] nal_length_i,
  input  logic [31:0]            timestamp_i,
  input  logic [6:0]             payload_type_i,
  input  logic [12:0]            fragment_limit_i,
  output h264fua_pkg::run_t      run_o
);

  // Common compare width: covers both the length and the limit plus a carry
  localparam int unsigned CW = ((LENGTH_BITS > 13) ? LENGTH_BITS : 13) + 2;

  logic [LENGTH_BITS-1:0] byte_index_q, byte_index_d;
  logic [12:0]            packet_fill_q, packet_fill_d;
  logic [15:0]            seq_q, seq_d;
  logic [7:0]             header_q;
  logic                   frag_q;
  logic [31:0]            held_ts_q;
  logic [LENGTH_BITS-1:0] held_len_q;

  logic                   first;
  logic [12:0]            lim;
  logic [LENGTH_BITS-1:0] len_in, len_c;
  logic [31:0]            ts_c;
  logic [7:0]             hb_c;
  logic                   frag_c;
  logic [12:0]            fill_c;
  logic [CW-1:0]          lenx, ix, limx, fillx, px, sx, remx, plenx;
  logic                   last, unit_end, span_end, end_c;
  logic [7:0]             ind_byte, hdr_byte;
  h264fua_pkg::result_t   base;

  // Effective limit, clamped to the legal range
  always_comb begin
    if (fragment_limit_i < h264fua_pkg::LIMIT_MIN) begin
      lim = h264fua_pkg::LIMIT_MIN;
    end else if (fragment_limit_i > h264fua_pkg::LIMIT_MAX) begin
      lim = h264fua_pkg::LIMIT_MAX;
    end else begin
      lim = fragment_limit_i;
    end
  end

  // Unit context: sampled from the request on the first byte, held after
  assign first  = (byte_index_q == '0);
  assign len_in = (nal_length_i == '0) ? LENGTH_BITS'(1) : nal_length_i;
  assign len_c  = first ? len_in : held_len_q;
  assign ts_c   = first ? timestamp_i : held_ts_q;
  assign hb_c   = first ? data_byte_i : header_q;
  assign frag_c = first ? (CW'(len_in) > CW'(lim)) : frag_q;
  assign fill_c = first ? 13'd0 : packet_fill_q;

  // Fragment position arithmetic
  assign lenx     = CW'(len_c);
  assign ix       = CW'(byte_index_q);
  assign limx     = CW'(lim);
  assign fillx    = CW'(fill_c);
  assign px       = (fillx > ix) ? ix : fillx;
  assign sx       = ix - px;
  assign remx     = lenx - sx;
  assign last     = (remx <= limx);
  assign unit_end = ((ix + CW'(1)) >= lenx);
  assign span_end = ((px + CW'(1)) >= limx);

  always_comb begin
    if (sx == '0) begin
      plenx = limx + CW'(1);
    end else if (last) begin
      plenx = remx + CW'(2);
    end else begin
      plenx = limx + CW'(2);
    end
  end

  assign ind_byte = {hb_c[7:5], h264fua_pkg::FU_A_TYPE};
  assign hdr_byte = {(last ? h264fua_pkg::FU_END : h264fua_pkg::FU_MID), hb_c[4:0]};

  // Result assembly and next state
  always_comb begin
    base               = '0;
    base.sequence_res  = seq_q;
    base.timestamp_out = ts_c;
    base.type_out      = payload_type_i;

    run_o         = '0;
    run_o.res[0]  = base;
    run_o.res[1]  = base;
    run_o.res[2]  = base;
    packet_fill_d = 13'd0;
    end_c         = 1'b0;

    if (!frag_c) begin
      // Whole unit in one packet
      end_c                       = unit_end;
      run_o.cnt                   = 2'd1;
      run_o.res[0].out_byte       = data_byte_i;
      run_o.res[0].packet_start   = first;
      run_o.res[0].packet_end     = unit_end;
      run_o.res[0].marker         = 1'b1;
      run_o.res[0].packet_length  = lenx[12:0];
      run_o.res[0].last_of_run    = 1'b1;
    end else if (first) begin
      // NAL header is replaced by FU indicator and start header
      run_o.cnt                   = 2'd2;
      run_o.res[0].out_byte       = ind_byte;
      run_o.res[0].packet_start   = 1'b1;
      run_o.res[0].packet_length  = lim + 13'd1;
      run_o.res[1].out_byte       = {h264fua_pkg::FU_START, hb_c[4:0]};
      run_o.res[1].packet_length  = lim + 13'd1;
      run_o.res[1].last_of_run    = 1'b1;
      packet_fill_d               = 13'd1;
    end else begin
      end_c         = unit_end || span_end;
      packet_fill_d = end_c ? 13'd0 : 13'(px + CW'(1));
      if (px == '0) begin
        // New fragment: indicator, header, then data
        run_o.cnt                   = 2'd3;
        run_o.res[0].out_byte       = ind_byte;
        run_o.res[0].packet_start   = 1'b1;
        run_o.res[0].marker         = last;
        run_o.res[0].packet_length  = plenx[12:0];
        run_o.res[1].out_byte       = hdr_byte;
        run_o.res[1].marker         = last;
        run_o.res[1].packet_length  = plenx[12:0];
        run_o.res[2].out_byte       = data_byte_i;
        run_o.res[2].packet_end     = end_c;
        run_o.res[2].marker         = last;
        run_o.res[2].packet_length  = plenx[12:0];
        run_o.res[2].last_of_run    = 1'b1;
      end else begin
        run_o.cnt                   = 2'd1;
        run_o.res[0].out_byte       = data_byte_i;
        run_o.res[0].packet_end     = end_c;
        run_o.res[0].marker         = last;
        run_o.res[0].packet_length  = plenx[12:0];
        run_o.res[0].last_of_run    = 1'b1;
      end
    end

    seq_d        = end_c ? (seq_q + 16'd1) : seq_q;
    byte_index_d = unit_end ? '0 : LENGTH_BITS'(ix + CW'(1));
    if (unit_end) begin
      packet_fill_d = 13'd0;
    end
  end

  // State registers, updated on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q  <= '0;
      packet_fill_q <= '0;
      seq_q         <= '0;
      header_q      <= '0;
      frag_q        <= 1'b0;
      held_ts_q     <= '0;
      held_len_q    <= '0;
    end else if (accept_i) begin
      byte_index_q  <= byte_index_d;
      packet_fill_q <= packet_fill_d;
      seq_q         <= seq_d;
      header_q      <= hb_c;
      frag_q        <= frag_c;
      held_ts_q     <= ts_c;
      held_len_q    <= len_c;
    end
  end

  // Mid-unit position stays inside the unit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (byte_index_q != '0) |-> (CW'(byte_index_q) < CW'(held_len_q)))
    else $error("byte index beyond unit length");

  // Sequence number changes only after an accepted request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(accept_i) |-> $stable(seq_q))
    else $error("sequence changed without a request");

endmodule

### sv/h264fua_obuf.sv
// Three-entry result buffer that serializes one run onto the output channel.
module h264fua_obuf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  h264fua_pkg::run_t    run_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output h264fua_pkg::result_t out_res_o
);

  h264fua_pkg::result_t [h264fua_pkg::MAX_RES-1:0] buf_q, buf_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop, load;

  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && out_ready_i;
  // Room for a new run once the buffer drains this cycle
  assign in_ready_o  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i);
  assign load        = in_valid_i && in_ready_o;
  assign out_res_o   = buf_q[0];

  // Load a run or shift the head out
  always_comb begin
    buf_d = buf_q;
    cnt_d = cnt_q;
    if (load) begin
      buf_d = run_i.res;
      cnt_d = run_i.cnt;
    end else if (pop) begin
      buf_d[0] = buf_q[1];
      buf_d[1] = buf_q[2];
      cnt_d    = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  // Count three never follows an empty buffer that took no run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3 || !$past(cnt_q == 2'd0 && !load))
    else $error("buffer count out of range");

  // Head carries the run end flag exactly when it is the last entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != 2'd0) |-> (buf_q[0].last_of_run == (cnt_q == 2'd1)))
    else $error("run end flag misplaced");

endmodule

### sv/h264fua_top_unused_placeholder.sv
// Configuration registers of the H.264 FU-A fragmenter.
module h264fua_cfg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wr_valid_i,
  input  logic [0:0]  wr_index_i,
  input  logic [12:0] wr_data_i,
  output logic [6:0]  payload_type_o,
  output logic [12:0] fragment_limit_o
);

  logic [6:0]  pt_q;
  logic [12:0] lim_q;

  // Register writes by index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_q  <= h264fua_pkg::PT_RESET;
      lim_q <= h264fua_pkg::LIMIT_RESET;
    end else if (wr_valid_i) begin
      case (h264fua_pkg::cfg_idx_e'(wr_index_i))
        h264fua_pkg::CFG_PAYLOAD_TYPE:   pt_q  <= wr_data_i[6:0];
        h264fua_pkg::CFG_FRAGMENT_LIMIT: lim_q <= wr_data_i;
        default: ;
      endcase
    end
  end

  assign payload_type_o   = pt_q;
  assign fragment_limit_o = lim_q;

endmodule

### sv/h264_fu_a_fragmenter.sv
// H.264 FU-A fragmenter: takes NAL unit bytes one per request and emits RTP payload
// bytes with packet boundaries, sequence number, timestamp and length. A data byte
// that continues a packet yields one result, so such bytes flow at one per cycle while
// the output is not stalled, each result appearing in the cycle after its request. The
// byte that opens a fragment yields two (first fragment) or three results, and the
// three-entry output buffer drains one result per cycle while the output is ready.
// The buffer accepts the next request in the cycle its last entry is taken.
module h264_fu_a_fragmenter #(
  parameter int unsigned LENGTH_BITS = h264fua_pkg::LENGTH_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  h264fua_in_if.sink    in_i,
  h264fua_out_if.source out_o,
  h264fua_cfg_if.sink   cfg_i
);

  logic [6:0]           payload_type;
  logic [12:0]          fragment_limit;
  logic                 accept;
  h264fua_pkg::run_t    run;
  h264fua_pkg::result_t head;

  // Configuration is always accepted
  assign cfg_i.ready = 1'b1;

  h264fua_cfg u_cfg (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .wr_valid_i       (cfg_i.valid),
    .wr_index_i       (cfg_i.index),
    .wr_data_i        (cfg_i.data),
    .payload_type_o   (payload_type),
    .fragment_limit_o (fragment_limit)
  );

  assign accept = in_i.valid && in_i.ready;

  h264fua_core #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .data_byte_i      (in_i.data_byte),
    .nal_length_i     (in_i.nal_length),
    .timestamp_i      (in_i.timestamp),
    .payload_type_i   (payload_type),
    .fragment_limit_i (fragment_limit),
    .run_o            (run)
  );

  h264fua_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .run_i       (run),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_res_o   (head)
  );

  // Result fields onto the output channel
  assign out_o.out_byte      = head.out_byte;
  assign out_o.packet_start  = head.packet_start;
  assign out_o.packet_end    = head.packet_end;
  assign out_o.marker        = head.marker;
  assign out_o.sequence_res  = head.sequence_res;
  assign out_o.timestamp_out = head.timestamp_out;
  assign out_o.packet_length = head.packet_length;
  assign out_o.type_out      = head.type_out;
  assign out_o.last_of_run   = head.last_of_run;

  // A packet start never also closes a fragmented packet's first byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.packet_start && !out_o.last_of_run) |-> !out_o.packet_end)
    else $error("header byte flagged as packet end");

endmodule

### tb/sv/tb_h264_fu_a_fragmenter.sv
`timescale 1ns / 1ps
// Self-checking testbench of the H.264 FU-A fragmenter with a byte-level predictor.
module tb_h264_fu_a_fragmenter;

  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned PHASE_BYTES  = 32;
  localparam int unsigned MAX_REPORTED = 10;

  // Predicts the payload bytes of the fragmenter and checks them in order
  class fua_scoreboard;
    logic [6:0]           pt_reg;
    logic [12:0]          limit_reg;
    logic [23:0]          byte_idx;
    logic [12:0]          fill;
    logic [15:0]          pkt_seq;
    logic [7:0]           nal_hdr;
    bit                   fu_mode;
    logic [31:0]          unit_ts;
    logic [23:0]          unit_len;
    h264fua_pkg::result_t payload_q[$];
    int unsigned          n_requests;
    int unsigned          n_checked;
    int unsigned          n_packets;
    int unsigned          n_mismatch;

    function new();
      pt_reg     = h264fua_pkg::PT_RESET;
      limit_reg  = h264fua_pkg::LIMIT_RESET;
      byte_idx   = '0;
      fill       = '0;
      pkt_seq    = '0;
      nal_hdr    = '0;
      fu_mode    = 1'b0;
      unit_ts    = '0;
      unit_len   = '0;
      n_requests = 0;
      n_checked  = 0;
      n_packets  = 0;
      n_mismatch = 0;
    endfunction

    function void write_reg(h264fua_pkg::cfg_idx_e idx, logic [12:0] val);
      case (idx)
        h264fua_pkg::CFG_PAYLOAD_TYPE:   pt_reg = val[6:0];
        h264fua_pkg::CFG_FRAGMENT_LIMIT: limit_reg = val;
        default: ;
      endcase
    endfunction

    // Fragment span after clamping the register to its legal range
    function int unsigned span_limit();
      if (limit_reg < h264fua_pkg::LIMIT_MIN) return h264fua_pkg::LIMIT_MIN;
      if (limit_reg > h264fua_pkg::LIMIT_MAX) return h264fua_pkg::LIMIT_MAX;
      return limit_reg;
    endfunction

    function int unsigned pending();
      return payload_q.size();
    endfunction

    function h264fua_pkg::result_t make_res(logic [7:0] b, bit st, bit en, bit mk,
                                            int unsigned plen);
      h264fua_pkg::result_t r;
      r.out_byte      = b;
      r.packet_start  = st;
      r.packet_end    = en;
      r.marker        = mk;
      r.sequence_res  = pkt_seq;
      r.timestamp_out = unit_ts;
      r.packet_length = plen[12:0];
      r.type_out      = pt_reg;
      r.last_of_run   = 1'b0;
      return r;
    endfunction

    // Expected payload bytes of one accepted input byte
    function void note_request(logic [7:0] b, logic [23:0] nal_len, logic [31:0] ts);
      int unsigned          lim, len, i, p, s, rem, plen;
      logic [7:0]           fu_ind;
      logic [4:0]           nal_type;
      bit                   last, ends;
      h264fua_pkg::result_t run_q[$];
      n_requests++;
      lim = span_limit();
      // first byte of a unit samples length, timestamp and NAL header
      if (byte_idx == '0) begin
        len = 32'(nal_len);
        if (len == 0) len = 1;
        unit_len = len[23:0];
        unit_ts  = ts;
        nal_hdr  = b;
        fill     = '0;
        fu_mode  = (len > lim);
      end
      len      = 32'(unit_len);
      i        = 32'(byte_idx);
      fu_ind   = {nal_hdr[7:5], h264fua_pkg::FU_A_TYPE};
      nal_type = nal_hdr[4:0];
      if (!fu_mode) begin
        // whole unit in one packet
        ends  = (i + 1 >= len);
        run_q = {run_q, make_res(b, i == 0, ends, 1'b1, len)};
        fill  = '0;
      end else if (i == 0) begin
        // NAL header is replaced by FU indicator and start header
        run_q = {run_q, make_res(fu_ind, 1'b1, 1'b0, 1'b0, lim + 1)};
        run_q = {run_q, make_res({h264fua_pkg::FU_START, nal_type}, 1'b0, 1'b0, 1'b0,
                                 lim + 1)};
        ends = 1'b0;
        fill = 13'd1;
      end else begin
        p = 32'(fill);
        if (p > i) p = i;
        s    = i - p;
        rem  = len - s;
        last = (rem <= lim);
        if (s == 0) plen = lim + 1;
        else if (last) plen = rem + 2;
        else plen = lim + 2;
        // a new fragment opens with indicator and header
        if (p == 0) begin
          run_q = {run_q, make_res(fu_ind, 1'b1, 1'b0, last, plen)};
          run_q = {run_q, make_res({last ? h264fua_pkg::FU_END : h264fua_pkg::FU_MID,
                                    nal_type}, 1'b0, 1'b0, last, plen)};
        end
        ends  = (i + 1 >= len) || (p + 1 >= lim);
        run_q = {run_q, make_res(b, 1'b0, ends, last, plen)};
        fill  = ends ? 13'd0 : 13'(p + 1);
      end
      run_q[run_q.size() - 1].last_of_run = 1'b1;
      payload_q = {payload_q, run_q};
      if (ends) pkt_seq = pkt_seq + 16'd1;
      if (i + 1 >= len) begin
        byte_idx = '0;
        fill     = '0;
      end else begin
        byte_idx = 24'(i + 1);
      end
    endfunction

    // Compare one output result with the oldest expectation
    function void check_result(h264fua_pkg::result_t got);
      h264fua_pkg::result_t want;
      string                bad;
      if (got.packet_end) n_packets++;
      if (payload_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTED)
          $display("ERROR: unexpected result byte=%h seq=%0d", got.out_byte, got.sequence_res);
        return;
      end
      want = payload_q.pop_front();
      n_checked++;
      bad = "";
      if (got.out_byte !== want.out_byte) bad = {bad, " out_byte"};
      if (got.packet_start !== want.packet_start) bad = {bad, " packet_start"};
      if (got.packet_end !== want.packet_end) bad = {bad, " packet_end"};
      if (got.marker !== want.marker) bad = {bad, " marker"};
      if (got.sequence_res !== want.sequence_res) bad = {bad, " sequence_res"};
      if (got.timestamp_out !== want.timestamp_out) bad = {bad, " timestamp_out"};
      if (got.packet_length !== want.packet_length) bad = {bad, " packet_length"};
      if (got.type_out !== want.type_out) bad = {bad, " type_out"};
      if (got.last_of_run !== want.last_of_run) bad = {bad, " last_of_run"};
      if (bad != "") begin
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTED) begin
          $display("ERROR: result %0d differs in%s", n_checked, bad);
          $display("  exp byte=%h st=%b en=%b mk=%b seq=%0d ts=%h len=%0d pt=%0d lr=%b",
                   want.out_byte, want.packet_start, want.packet_end, want.marker,
                   want.sequence_res, want.timestamp_out, want.packet_length,
                   want.type_out, want.last_of_run);
          $display("  act byte=%h st=%b en=%b mk=%b seq=%0d ts=%h len=%0d pt=%0d lr=%b",
                   got.out_byte, got.packet_start, got.packet_end, got.marker,
                   got.sequence_res, got.timestamp_out, got.packet_length,
                   got.type_out, got.last_of_run);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  h264fua_in_if #(.LENGTH_BITS(24)) in_if ();
  h264fua_out_if                    out_if ();
  h264fua_cfg_if                    cfg_if ();

  h264_fu_a_fragmenter #(.LENGTH_BITS(24)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  fua_scoreboard sb = new();

  bit          bursty;
  bit          long_hold_req;
  int unsigned unit_left;
  int unsigned n_settings;
  int unsigned quiet_cycles = 0;

  // Register settings walked by the random part
  logic [6:0]  pt_set  [10] = '{7'd0, 7'd127, 7'd33, 7'd64, 7'd1, 7'd85, 7'd42, 7'd96,
                                7'd10, 7'd96};
  logic [12:0] lim_set [10] = '{13'd16, 13'd5, 13'd17, 13'd0, 13'd40, 13'd100, 13'd8191,
                                13'd4096, 13'd23, 13'd1400};

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function int unsigned gap_len();
    if ($urandom_range(0, 19) < 17) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Unit lengths around the fragment boundaries; short units for large spans
  function logic [23:0] pick_len(int unsigned lim);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (lim > 128) begin
      if (r == 0) return 24'd0;
      if (r == 9) return 24'($urandom_range(65, 200));
      return 24'($urandom_range(1, 64));
    end
    case (r)
      0:       return 24'd0;
      1:       return 24'($urandom_range(1, 3));
      2:       return 24'(lim);
      3:       return 24'(lim + 1);
      4:       return 24'(2 * lim);
      5:       return 24'(2 * lim + 1);
      6:       return 24'(3 * lim);
      7:       return 24'(lim - 1);
      default: return 24'($urandom_range(1, 3 * lim));
    endcase
  endfunction

  // One byte request; valid stays high across back-to-back requests
  task automatic send_req(logic [7:0] b, logic [23:0] nal_len, logic [31:0] ts);
    int unsigned g;
    g = (!bursty && $urandom_range(0, 3) == 0) ? gap_len() : 0;
    if (g > 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.data_byte  <= b;
    in_if.nal_length <= nal_len;
    in_if.timestamp  <= ts;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_request(b, nal_len, ts);
  endtask

  // Next byte of the running stream, opening a fresh unit when needed
  task automatic stream_byte();
    logic [23:0] nal;
    if (unit_left == 0) begin
      nal = pick_len(sb.span_limit());
      unit_left = (nal == 0) ? 1 : 32'(nal);
    end else begin
      nal = 24'($urandom);
    end
    send_req(8'($urandom), nal, $urandom);
    unit_left--;
  endtask

  task automatic run_bytes(int unsigned n);
    repeat (n) stream_byte();
  endtask

  // Finish the open unit, then start one of a given length and header
  task automatic begin_unit(logic [23:0] len, logic [7:0] hdr, logic [31:0] ts);
    run_bytes(unit_left);
    unit_left = (len == 0) ? 1 : 32'(len);
    send_req(hdr, len, ts);
    unit_left--;
  endtask

  // Stop requesting until every expected result is out
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Write both registers back to back; only called with the block idle
  task automatic set_config(logic [6:0] pt, logic [12:0] lim);
    h264fua_pkg::cfg_idx_e idx;
    for (int k = 0; k < 2; k++) begin
      idx = (k == 0) ? h264fua_pkg::CFG_PAYLOAD_TYPE : h264fua_pkg::CFG_FRAGMENT_LIMIT;
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx;
      cfg_if.data  <= (k == 0) ? {6'd0, pt} : lim;
      @(posedge clk_i);
      while (!cfg_if.ready) @(posedge clk_i);
      sb.write_reg(idx, (k == 0) ? {6'd0, pt} : lim);
    end
    cfg_if.valid <= 1'b0;
    n_settings++;
  endtask

  // Receiver: random stalls, one long hold on request
  initial begin
    int unsigned stall_cnt;
    stall_cnt = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_cnt > 0) begin
        stall_cnt--;
        out_if.ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_cnt = LONG_HOLD;
        out_if.ready <= 1'b0;
      end else if (!bursty && $urandom_range(0, 3) == 0) begin
        stall_cnt = gap_len() - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Result monitor and stall watchdog
  always @(posedge clk_i) begin
    h264fua_pkg::result_t got;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got.out_byte      = out_if.out_byte;
        got.packet_start  = out_if.packet_start;
        got.packet_end    = out_if.packet_end;
        got.marker        = out_if.marker;
        got.sequence_res  = out_if.sequence_res;
        got.timestamp_out = out_if.timestamp_out;
        got.packet_length = out_if.packet_length;
        got.type_out      = out_if.type_out;
        got.last_of_run   = out_if.last_of_run;
        sb.check_result(got);
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("ERROR: no request moved for %0d cycles", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Main sequence
  initial begin
    rst_ni           = 1'b0;
    bursty           = 1'b0;
    long_hold_req    = 1'b0;
    unit_left        = 0;
    n_settings       = 0;
    in_if.valid      <= 1'b0;
    in_if.data_byte  <= '0;
    in_if.nal_length <= '0;
    in_if.timestamp  <= '0;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= h264fua_pkg::CFG_PAYLOAD_TYPE;
    cfg_if.data      <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, zero length, one-byte and short whole units
    begin_unit(24'd0, 8'hFF, 32'hFFFF_FFFF);
    begin_unit(24'd1, 8'h00, 32'h0000_0000);
    begin_unit(24'd3, 8'h65, 32'h1234_5678);
    run_bytes(unit_left);
    drain();
    // Directed: smallest span, unit one byte over it is fragmented
    set_config(7'd127, h264fua_pkg::LIMIT_MIN);
    begin_unit(24'd17, 8'hFF, 32'hFFFF_FFFF);
    run_bytes(unit_left);
    drain();

    // Span changed twice inside one unit
    begin_unit(24'd60, 8'h7C, $urandom);
    run_bytes(20);
    drain();
    set_config(7'd5, 13'd40);
    run_bytes(10);
    drain();
    set_config(7'd6, 13'd17);
    run_bytes(unit_left);

    // Random phases over the register settings
    for (int ph = 0; ph < 10; ph++) begin
      drain();
      set_config(pt_set[ph], lim_set[ph]);
      bursty = (ph == 1) || ($urandom_range(0, 3) == 0);
      if (ph == 1) long_hold_req = 1'b1;
      run_bytes(PHASE_BYTES);
    end
    run_bytes(unit_left);
    drain();
    bursty = 1'b1;
    repeat (8) @(posedge clk_i);

    if (sb.pending() != 0) $display("ERROR: %0d results never arrived", sb.pending());
    $display("Run covered %0d byte requests, %0d payload results in %0d packets,",
             sb.n_requests, sb.n_checked, sb.n_packets);
    $display("over %0d register settings including span extremes and mid-unit changes.",
             n_settings);
    if (sb.n_mismatch == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### filelist.f
sv/h264fua_pkg.sv
sv/h264fua_if.sv
sv/h264fua_core.sv
sv/h264fua_obuf.sv
sv/h264fua_top_unused_placeholder.sv
sv/h264_fu_a_fragmenter.sv
tb/sv/tb_h264_fu_a_fragmenter.sv
